// ===== src/fbba_pkg.sv =====
`timescale 1ns / 1ps
package fbba_pkg;

	// payload widths
	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 12;
	localparam int COUNT_W  = 13;
	localparam int TOTAL_W  = 13;
	localparam int STATUS_W = 2;
	localparam int FREE_W   = 13;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_SET   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_CLR   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TEST  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_REL   = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic start;
		logic read;
		logic scan;
		logic mark;
		logic publish;
	} fbba_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic alloc;
		logic found;
		logic scan_last;
		logic mark_last;
		logic out_busy;
	} fbba_sts_t;

endpackage

// ===== src/fbba_if.sv =====
`timescale 1ns / 1ps
interface fbba_req_if;
	logic                          valid;
	logic                          ready;
	logic [fbba_pkg::OPCODE_W-1:0] opcode;
	logic [fbba_pkg::INDEX_W-1:0]  block_index;
	logic [fbba_pkg::COUNT_W-1:0]  block_count;

	modport source (output valid, opcode, block_index, block_count, input ready);
	modport sink   (input valid, opcode, block_index, block_count, output ready);
endinterface

interface fbba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fbba_pkg::STATUS_W-1:0] status;
	logic [fbba_pkg::INDEX_W-1:0]  start_block;
	logic                          is_used;
	logic [fbba_pkg::FREE_W-1:0]   free_count;

	modport source (output valid, status, start_block, is_used, free_count, input ready);
	modport sink   (input valid, status, start_block, is_used, free_count, output ready);
endinterface

// ===== src/free_block_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps
// First-fit free-block bitmap allocator. One bit per block (1 = used) is held
// in a word-wide RAM of NUM_BLOCKS/WORD_BITS words, beside a free-block
// counter; everything is free after reset, with no clearing pass, since a
// per-word valid flag makes unwritten words read as free. Each request is
// set used, clear, test, allocate a run (lowest start of block_count free
// blocks below the limit) or release a run; the limit is total_blocks capped
// at NUM_BLOCKS, and indices, counts or runs past it answer "invalid" without
// touching anything. The counter moves by one per bit that really flips.
// One request is in flight at a time: the RAM is visited read-then-process,
// one word at a time. An invalid request answers without visiting the RAM; a
// release visits each word it covers; an allocate scans words up to where its
// run ends and then visits each word of the run, or scans every word below
// the limit when it finds none. The response sits in an output register, so
// a new request may be taken while a response is still waiting. WORD_BITS
// must be a power of two. total_blocks is written through cfg_we/cfg_wdata;
// the user must write it only while no request is in flight, and the block
// itself does not enforce this.
module free_block_bitmap_allocator_top #(
	parameter int NUM_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fbba_pkg::TOTAL_W-1:0] cfg_wdata,
	fbba_req_if.sink                     req,
	fbba_rsp_if.source                   rsp
);
	fbba_pkg::fbba_cmd_t cmd;
	fbba_pkg::fbba_sts_t sts;

	// sequencer: decode, word scan, word update, response hand-off
	fbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap RAM, run search, counter and response register
	fbba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.opcode      (req.opcode),
		.block_index (req.block_index),
		.block_count (req.block_count),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.status      (rsp.status),
		.start_block (rsp.start_block),
		.is_used     (rsp.is_used),
		.free_count  (rsp.free_count)
	);
endmodule

// ===== src/fbba_ram.sv =====
`timescale 1ns / 1ps
module fbba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/fbba_ctrl.sv =====
`timescale 1ns / 1ps
module fbba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fbba_pkg::fbba_sts_t sts,
	output fbba_pkg::fbba_cmd_t cmd
);
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_SCAN_RD = 3'd2;
	localparam logic [2:0] S_SCAN_EX = 3'd3;
	localparam logic [2:0] S_MARK_RD = 3'd4;
	localparam logic [2:0] S_MARK_EX = 3'd5;
	localparam logic [2:0] S_SETTLE  = 3'd6;
	localparam logic [2:0] S_FINISH  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.start = 1'b1;
				priority if (sts.bad) begin
					state_d = S_FINISH;
				end else if (sts.alloc) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_MARK_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.read = 1'b1;
				state_d  = S_SCAN_EX;
			end
			S_SCAN_EX: begin
				cmd.scan = 1'b1;
				priority if (sts.found) begin
					state_d = S_MARK_RD;
				end else if (sts.scan_last) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_MARK_RD: begin
				cmd.read = 1'b1;
				state_d  = S_MARK_EX;
			end
			S_MARK_EX: begin
				cmd.mark = 1'b1;
				state_d  = sts.mark_last ? S_SETTLE : S_MARK_RD;
			end
			S_SETTLE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== src/fbba_datapath.sv =====
`timescale 1ns / 1ps
module fbba_datapath #(
	parameter int NUM_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fbba_pkg::TOTAL_W-1:0]  cfg_wdata,
	input  logic [fbba_pkg::OPCODE_W-1:0] opcode,
	input  logic [fbba_pkg::INDEX_W-1:0]  block_index,
	input  logic [fbba_pkg::COUNT_W-1:0]  block_count,
	input  fbba_pkg::fbba_cmd_t           cmd,
	output fbba_pkg::fbba_sts_t           sts,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [fbba_pkg::STATUS_W-1:0] status,
	output logic [fbba_pkg::INDEX_W-1:0]  start_block,
	output logic                          is_used,
	output logic [fbba_pkg::FREE_W-1:0]   free_count
);
	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int S         = $clog2(WORD_BITS);
	localparam int CW        = $clog2(NUM_BLOCKS + 1);
	localparam int LIM_W     = CW > fbba_pkg::TOTAL_W ? CW : fbba_pkg::TOTAL_W;
	localparam int XW        = LIM_W + 1;
	localparam int PW        = $clog2(WORD_BITS + 1);

	// request and progress
	logic [fbba_pkg::OPCODE_W-1:0] op_q;
	logic [fbba_pkg::INDEX_W-1:0]  idx_q;
	logic [fbba_pkg::COUNT_W-1:0]  cnt_q;
	logic [LIM_W-1:0]              lim_q;
	logic [fbba_pkg::TOTAL_W-1:0]  total_q;
	logic [AW-1:0]                 wptr_q;
	logic [XW-1:0]                 run_q;
	logic [XW-1:0]                 lo_q;
	logic [XW-1:0]                 hi_q;
	logic [fbba_pkg::STATUS_W-1:0] stat_q;
	logic [fbba_pkg::INDEX_W-1:0]  start_q;
	logic                          used_q;
	logic [PW-1:0]                 flips_q;
	logic                          flip_dec_q;
	logic [CW-1:0]                 free_q;
	logic [MAP_WORDS-1:0]          valid_q;
	logic                          vld_s1;
	logic [WORD_BITS-1:0]          rdata;

	// response register
	logic                          rsp_valid_q;
	logic [fbba_pkg::STATUS_W-1:0] rsp_status_q;
	logic [fbba_pkg::INDEX_W-1:0]  rsp_start_q;
	logic                          rsp_used_q;
	logic [fbba_pkg::FREE_W-1:0]   rsp_free_q;

	logic [LIM_W-1:0]     tot_x;
	logic [LIM_W-1:0]     lim_next;
	logic [XW-1:0]        idx_x;
	logic [XW-1:0]        cnt_x;
	logic [XW-1:0]        lim_x;
	logic [XW-1:0]        wbase;
	logic                 bad;
	logic                 set_mode;
	logic                 clr_mode;
	logic                 wr_en;
	logic [WORD_BITS-1:0] eff;
	logic [WORD_BITS-1:0] blocked;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cnt_gt;
	logic [WORD_BITS-1:0] fit;
	logic [WORD_BITS-1:0] flipv;
	logic [XW-1:0]        pos [WORD_BITS];
	logic                 found;
	logic [S-1:0]         jf;
	logic [S-1:0]         hb;
	logic [XW-1:0]        s_pos;
	logic [XW-1:0]        new_run;
	logic [PW-1:0]        pc;
	logic                 scan_last;
	logic                 mark_last;

	assign tot_x    = LIM_W'(total_q);
	assign lim_next = (tot_x < LIM_W'(NUM_BLOCKS)) ? tot_x : LIM_W'(NUM_BLOCKS);
	assign idx_x    = XW'(idx_q);
	assign cnt_x    = XW'(cnt_q);
	assign lim_x    = XW'(lim_q);
	assign wbase    = XW'(wptr_q) << S;
	assign set_mode = (op_q == fbba_pkg::OP_SET) || (op_q == fbba_pkg::OP_ALLOC);
	assign clr_mode = (op_q == fbba_pkg::OP_CLR) || (op_q == fbba_pkg::OP_REL);
	assign wr_en    = cmd.mark && (set_mode || clr_mode);
	assign eff      = vld_s1 ? rdata : '0;

	always_comb begin
		unique case (op_q)
			fbba_pkg::OP_SET, fbba_pkg::OP_CLR, fbba_pkg::OP_TEST: begin
				bad = !(idx_x < lim_x);
			end
			fbba_pkg::OP_ALLOC: begin
				bad = (cnt_x == '0) || (cnt_x > lim_x);
			end
			fbba_pkg::OP_REL: begin
				bad = (cnt_x == '0) || ((idx_x + cnt_x) > lim_x);
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// per-bit view of the current word
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			pos[j]     = wbase + XW'(j);
			blocked[j] = eff[j] | !(pos[j] < lim_x);
			mask[j]    = (pos[j] >= lo_q) && (pos[j] < hi_q);
			cnt_gt[j]  = cnt_x > XW'(j);
		end
	end

	// bit j ends a fitting run when the cnt-wide window ending there is clear,
	// reaching into the carried run from lower words when the window spills over
	always_comb begin
		logic clear_j;
		logic carry_ok;
		for (int j = 0; j < WORD_BITS; j++) begin
			clear_j = 1'b1;
			for (int k = 0; k < WORD_BITS; k++) begin
				if (k <= j) begin
					if (cnt_gt[j - k] && blocked[k]) begin
						clear_j = 1'b0;
					end
				end
			end
			carry_ok = !cnt_gt[j] || ((run_q + XW'(j + 1)) >= cnt_x);
			fit[j]   = clear_j && carry_ok;
		end
	end

	always_comb begin
		found = 1'b0;
		jf    = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (fit[j]) begin
				found = 1'b1;
				jf    = S'(j);
			end
		end
	end

	always_comb begin
		hb = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (blocked[j]) begin
				hb = S'(j);
			end
		end
	end

	assign s_pos   = wbase + XW'(jf) + XW'(1) - cnt_x;
	assign new_run = (|blocked) ? (XW'(WORD_BITS - 1) - XW'(hb)) : (run_q + XW'(WORD_BITS));

	always_comb begin
		if (set_mode) begin
			flipv = mask & ~eff;
		end else if (clr_mode) begin
			flipv = mask & eff;
		end else begin
			flipv = '0;
		end
	end

	always_comb begin
		pc = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pc = pc + PW'(flipv[j]);
		end
	end

	assign scan_last = wptr_q == AW'((lim_x - XW'(1)) >> S);
	assign mark_last = wptr_q == AW'((hi_q - XW'(1)) >> S);

	assign sts.bad       = bad;
	assign sts.alloc     = op_q == fbba_pkg::OP_ALLOC;
	assign sts.found     = found;
	assign sts.scan_last = scan_last;
	assign sts.mark_last = mark_last;
	assign sts.out_busy  = rsp_valid_q && !rsp_ready;

	fbba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wptr_q),
		.wdata (eff ^ flipv),
		.re    (cmd.read),
		.raddr (wptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= fbba_pkg::TOTAL_RESET;
			free_q      <= CW'(NUM_BLOCKS);
			valid_q     <= '0;
			flips_q     <= '0;
			flip_dec_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			flips_q    <= cmd.mark ? pc : '0;
			flip_dec_q <= set_mode;
			// counter is updated in the cycle after the map write
			if (flip_dec_q) begin
				free_q <= free_q - CW'(flips_q);
			end else begin
				free_q <= free_q + CW'(flips_q);
			end
			if (wr_en) begin
				valid_q[wptr_q] <= 1'b1;
			end
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			vld_s1 <= valid_q[wptr_q];
		end
		if (cmd.capture) begin
			op_q    <= opcode;
			idx_q   <= block_index;
			cnt_q   <= block_count;
			lim_q   <= lim_next;
			stat_q  <= fbba_pkg::ST_OK;
			start_q <= '0;
			used_q  <= 1'b0;
		end
		if (cmd.start) begin
			if (bad) begin
				stat_q <= fbba_pkg::ST_BAD;
			end else if (op_q == fbba_pkg::OP_ALLOC) begin
				wptr_q <= '0;
				run_q  <= '0;
			end else begin
				lo_q   <= idx_x;
				hi_q   <= idx_x + ((op_q == fbba_pkg::OP_REL) ? cnt_x : XW'(1));
				wptr_q <= AW'(idx_x >> S);
			end
		end
		if (cmd.scan) begin
			if (found) begin
				lo_q    <= s_pos;
				hi_q    <= s_pos + cnt_x;
				start_q <= fbba_pkg::INDEX_W'(s_pos);
				wptr_q  <= AW'(s_pos >> S);
			end else if (scan_last) begin
				stat_q <= fbba_pkg::ST_NOSPACE;
			end else begin
				wptr_q <= wptr_q + AW'(1);
				run_q  <= new_run;
			end
		end
		if (cmd.mark) begin
			if (op_q == fbba_pkg::OP_TEST) begin
				used_q <= eff[idx_q[S-1:0]];
			end
			wptr_q <= wptr_q + AW'(1);
		end
		if (cmd.publish) begin
			rsp_status_q <= stat_q;
			rsp_start_q  <= start_q;
			rsp_used_q   <= used_q;
			rsp_free_q   <= fbba_pkg::FREE_W'(free_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign start_block = rsp_start_q;
	assign is_used     = rsp_used_q;
	assign free_count  = rsp_free_q;
endmodule

// ===== src/fbba_checker.sv =====
`timescale 1ns / 1ps
module fbba_checker #(
	parameter int NUM_BLOCKS = 4096
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [fbba_pkg::STATUS_W-1:0] status,
	input logic [fbba_pkg::INDEX_W-1:0]  start_block,
	input logic                          is_used,
	input logic [fbba_pkg::FREE_W-1:0]   free_count
);
	// a held response keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(free_count)
			&& $stable(start_block) && $stable(is_used))
		else $error("response changed while stalled");

	// one request at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// failures report no block and no test hit
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != fbba_pkg::ST_OK) |-> (start_block == '0) && !is_used)
		else $error("failed request carries data");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> free_count <= NUM_BLOCKS)
		else $error("free count above block count");
endmodule

bind free_block_bitmap_allocator_top fbba_checker #(
	.NUM_BLOCKS (NUM_BLOCKS)
) u_fbba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.start_block (rsp.start_block),
	.is_used     (rsp.is_used),
	.free_count  (rsp.free_count)
);

// ===== test/free_block_bitmap_allocator_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels and the register port, keeps its own bitmap and free
// count, and checks every response against the oldest prediction.
module free_block_bitmap_allocator_checker #(
	parameter int NUM_BLOCKS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fbba_pkg::TOTAL_W-1:0] cfg_wdata,
	fbba_req_if                          req,
	fbba_rsp_if                          rsp,
	output int                           fail_count,
	output int                           outstanding
);
	import fbba_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  start_block;
		logic                is_used;
		logic [FREE_W-1:0]   free_count;
	} alloc_answer_t;

	logic               used_bits [NUM_BLOCKS];
	int                 free_left;
	logic [TOTAL_W-1:0] total_blocks;
	alloc_answer_t      answers_due [$];

	// counter follows real transitions only
	function automatic void mark_block(int blk, logic used);
		if (used && !used_bits[blk]) begin
			used_bits[blk] = 1'b1;
			free_left--;
		end else if (!used && used_bits[blk]) begin
			used_bits[blk] = 1'b0;
			free_left++;
		end
	endfunction

	function automatic alloc_answer_t allocator_step(logic [OPCODE_W-1:0] op,
			logic [INDEX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
		alloc_answer_t a;
		int            lim;
		int            run;
		int            first;
		int            i;
		bit            found;
		a = '0;
		a.status = ST_BAD;
		lim = (total_blocks < NUM_BLOCKS) ? int'(total_blocks) : NUM_BLOCKS;
		case (op)
			OP_SET, OP_CLR: begin
				if (int'(idx) < lim) begin
					mark_block(int'(idx), op == OP_SET);
					a.status = ST_OK;
				end
			end
			OP_TEST: begin
				if (int'(idx) < lim) begin
					a.is_used = used_bits[idx];
					a.status = ST_OK;
				end
			end
			OP_ALLOC: begin
				if (cnt != 0 && int'(cnt) <= lim) begin
					run = 0;
					first = 0;
					found = 1'b0;
					for (i = 0; i < lim && !found; i++) begin
						if (used_bits[i]) begin
							run = 0;
						end else begin
							if (run == 0)
								first = i;
							run++;
							if (run == int'(cnt))
								found = 1'b1;
						end
					end
					if (found) begin
						for (i = first; i < first + int'(cnt); i++)
							mark_block(i, 1'b1);
						a.start_block = INDEX_W'(first);
						a.status = ST_OK;
					end else begin
						a.status = ST_NOSPACE;
					end
				end
			end
			OP_REL: begin
				if (cnt != 0 && int'(idx) + int'(cnt) <= lim) begin
					for (i = int'(idx); i < int'(idx) + int'(cnt); i++)
						mark_block(i, 1'b0);
					a.status = ST_OK;
				end
			end
			default: ;
		endcase
		a.free_count = FREE_W'(free_left);
		return a;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_answer_t want;
		if (!arst_n) begin
			foreach (used_bits[i])
				used_bits[i] = 1'b0;
			free_left = NUM_BLOCKS;
			total_blocks = TOTAL_RESET;
			answers_due.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				total_blocks = cfg_wdata;
			// retire before predicting: a response here belongs to an older request
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("start_block", want.start_block, rsp.start_block);
					check_field("is_used", want.is_used, rsp.is_used);
					check_field("free_count", want.free_count, rsp.free_count);
				end
			end
			if (req.valid && req.ready)
				answers_due.push_back(allocator_step(req.opcode, req.block_index,
						req.block_count));
			outstanding <= answers_due.size();
		end
	end

endmodule

// ===== test/free_block_bitmap_allocator_top_tb.sv =====
`timescale 1ns / 1ps
module free_block_bitmap_allocator_top_tb;
	import fbba_pkg::*;

	localparam int NUM_BLOCKS    = 4096;
	localparam int STALL_MAX     = 13;     // per-request idle draw on either side
	localparam int LONG_HOLD     = 400;    // receiver hold-off to back the block up
	localparam int IDLE_LIMIT    = 20000;  // cycles with no handshake before giving up
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 55;
	localparam int BURST_ITEMS   = 24;

	// opcodes the block does not decode
	localparam logic [OPCODE_W-1:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_RSVD_LAST  = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [TOTAL_W-1:0] cfg_wdata;

	fbba_req_if req ();
	fbba_rsp_if rsp ();

	int fail_count;
	int outstanding;
	int idle_cycles = 0;
	int hold_asks;       // bumped to ask the receiver for one long hold-off
	int limit_now = NUM_BLOCKS;  // current effective limit, steers the stimulus
	bit req_burst;       // forces back-to-back requests
	bit req_steady;      // a stretch with no sender gaps
	int req_mode_left = 0;

	free_block_bitmap_allocator_top #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.WORD_BITS (32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	free_block_bitmap_allocator_checker #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) bitmap_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any handshake on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one request. Call it right after posedge clk; valid only drops when
	// a gap is drawn, so a request sent with no gap never sees valid pulse low.
	task automatic send_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
			logic [COUNT_W-1:0] cnt);
		int gap;
		if (req_mode_left == 0) begin
			req_steady = ($urandom_range(0, 2) == 0);
			req_mode_left = $urandom_range(10, 40);
		end
		req_mode_left--;
		gap = (req_burst || req_steady) ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.block_index <= idx;
		req.block_count <= cnt;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop offering and sit until every predicted response has been taken.
	task automatic drain_responses();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Register writes only happen with the block idle.
	task automatic set_total_blocks(logic [TOTAL_W-1:0] value);
		drain_responses();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_now = (value > NUM_BLOCKS) ? NUM_BLOCKS : int'(value);
	endtask

	function automatic int pick_index();
		if (limit_now > 0 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, limit_now - 1);
		return $urandom_range(0, NUM_BLOCKS - 1);
	endfunction

	// Run lengths: mostly short runs, now and then a huge or illegal one.
	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 39);
		if (r < 2)
			return 0;
		if (r < 4)
			return $urandom_range(NUM_BLOCKS, 8191);
		if (r < 7 && limit_now > 0)
			return $urandom_range(1, limit_now);
		return $urandom_range(1, 24);
	endfunction

	task automatic random_request();
		int r;
		int idx;
		int cnt;
		r = $urandom_range(0, 99);
		idx = pick_index();
		cnt = pick_count();
		if (r < 25) begin
			send_request(OP_ALLOC, 0, COUNT_W'(cnt));
		end else if (r < 40) begin
			// about one release in ten wipes the whole usable range
			if ($urandom_range(0, 9) == 0)
				send_request(OP_REL, 0, COUNT_W'(limit_now));
			else
				send_request(OP_REL, INDEX_W'(idx), COUNT_W'(cnt * 2));
		end else if (r < 55) begin
			send_request(OP_SET, INDEX_W'(idx), COUNT_W'(cnt));
		end else if (r < 67) begin
			send_request(OP_CLR, INDEX_W'(idx), COUNT_W'(cnt));
		end else if (r < 85) begin
			send_request(OP_TEST, INDEX_W'(idx), COUNT_W'(cnt));
		end else if (r < 92) begin
			send_request(OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)),
					INDEX_W'(idx), COUNT_W'(cnt));
		end else begin
			send_request(OPCODE_W'($urandom_range(0, 7)),
					INDEX_W'($urandom_range(0, NUM_BLOCKS - 1)),
					COUNT_W'($urandom_range(0, 8191)));
		end
	endtask

	// Receiver: its own idle draws, plus one long hold-off when asked.
	initial begin : rsp_side
		int stall;
		int holds_done;
		int mode_left;
		bit steady;
		holds_done = 0;
		mode_left = 0;
		steady = 1'b0;
		rsp.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (mode_left == 0) begin
				steady = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(10, 40);
			end
			mode_left--;
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				stall = LONG_HOLD;
			end else begin
				stall = steady ? 0 : $urandom_range(0, STALL_MAX);
			end
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin : stimulus
		int totals [9];
		int p;
		int k;
		// -1 stands for a random limit in range
		totals = '{4096, 8191, 1, 0, 64, -1, 4095, 33, -1};
		req_burst = 1'b0;
		req_steady = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= TOTAL_RESET;
		hold_asks <= 0;
		req.valid <= 1'b0;
		req.opcode <= OP_SET;
		req.block_index <= '0;
		req.block_count <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, at the reset limit of 4096 blocks.
		send_request(OP_TEST, 0, 0);               // fresh map reads free
		send_request(OP_SET, 0, 0);
		send_request(OP_SET, 0, 0);                // already used: no count change
		send_request(OP_TEST, 0, 0);
		send_request(OP_SET, 12'd4095, 13'd8191);  // top block, count ignored
		send_request(OP_TEST, 12'd4095, 0);
		send_request(OP_CLR, 12'd4095, 0);
		send_request(OP_CLR, 12'd4095, 0);         // already free
		send_request(OP_ALLOC, 0, 0);              // zero count
		send_request(OP_ALLOC, 0, 13'd4097);       // longer than the limit
		send_request(OP_ALLOC, 0, 13'd8191);
		send_request(OP_ALLOC, 0, 13'd3);          // first fit lands after block 0
		send_request(OP_ALLOC, 0, 13'd4096);       // no run that long left
		send_request(OP_REL, 0, 0);                // zero count
		send_request(OP_REL, 12'd4095, 13'd2);     // runs past the limit
		send_request(OP_REL, 12'd4095, 13'd1);     // already free
		send_request(OP_REL, 0, 13'd4096);         // everything back
		send_request(OP_ALLOC, 0, 13'd4096);       // whole map in one run
		send_request(OP_ALLOC, 0, 13'd1);          // full: no space
		send_request(OP_REL, 0, 13'd4096);
		for (k = 0; k <= int'(OP_RSVD_LAST - OP_RSVD_FIRST); k++)
			send_request(OPCODE_W'(int'(OP_RSVD_FIRST) + k), 12'd4095, 13'd8191);

		// Random phases, each under its own limit; includes limit zero
		// (nothing is valid) and a limit past the map (clamped).
		for (p = 0; p < 9; p++) begin
			if (totals[p] < 0)
				set_total_blocks(TOTAL_W'($urandom_range(1, NUM_BLOCKS)));
			else
				set_total_blocks(TOTAL_W'(totals[p]));
			if (p == 0) begin
				// Back-pressure: the receiver sits on a response for a long
				// stretch while fast requests keep coming, so the output
				// register fills and the block stops taking requests.
				hold_asks <= hold_asks + 1;
				req_burst = 1'b1;
				for (k = 0; k < BURST_ITEMS; k++)
					send_request(OPCODE_W'($urandom_range(OP_SET, OP_TEST)),
							INDEX_W'(pick_index()), 0);
				req_burst = 1'b0;
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				random_request();
				// now and then hold back until every response is in
				if ($urandom_range(0, 39) == 0)
					drain_responses();
			end
		end

		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== free_block_bitmap_allocator_top.f =====
src/fbba_pkg.sv
src/fbba_if.sv
src/fbba_ram.sv
src/fbba_ctrl.sv
src/fbba_datapath.sv
src/free_block_bitmap_allocator_top.sv
src/fbba_checker.sv
test/free_block_bitmap_allocator_checker.sv
test/free_block_bitmap_allocator_top_tb.sv
